@@ sv/tlpa_pkg.sv @@
// Shared types, field widths and codes for the two-level page table allocator.
package tlpa_pkg;

    // Fixed address split
    localparam int DIR_ENTRIES  = 1024;
    localparam int PAGE_ENTRIES = 1024;
    localparam int DIR_IDX_W    = 10;
    localparam int PAGE_IDX_W   = 10;
    localparam int OFFSET_W     = 12;
    localparam int DIR_SHIFT    = 22;
    localparam int PAGE_SHIFT   = 12;

    // Payload field widths
    localparam int PROC_ID_W    = 3;
    localparam int VADDR_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int FRAME_OUT_W  = 5;
    localparam int PADDR_W      = 17;
    localparam int RETURNED_W   = 6;

    // Default sizing
    localparam int DEF_NUM_PROCESSES = 8;
    localparam int DEF_NUM_FRAMES    = 32;

    localparam logic ACTION_TRANSLATE = 1'b0;
    localparam logic ACTION_RELEASE   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_MAPPED        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_FRAMES = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RELEASE_DONE  = 2'd2;

    typedef struct packed {
        logic                 action;
        logic [PROC_ID_W-1:0] process_id;
        logic [VADDR_W-1:0]   virtual_address;
    } tlpa_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   dir_fault;
        logic                   page_fault;
        logic [FRAME_OUT_W-1:0] frame;
        logic [PADDR_W-1:0]     physical_address;
        logic [RETURNED_W-1:0]  frames_returned;
    } tlpa_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TR_DIR,
        ST_TR_PAGE,
        ST_REL_DIR_RD,
        ST_REL_DIR_CHK,
        ST_REL_PAGE,
        ST_REL_DONE
    } tlpa_state_t;

endpackage

@@ sv/two_level_page_table_allocator.sv @@
// Translates per-process virtual addresses through a directory and a pool of second-level
// tables, handing out frames from a FIFO free-frame ring. A second-level table lives in the
// pool slot named by the first frame mapped under its directory entry, so the pool holds
// NUM_FRAMES tables. A translate reads the directory memory and, when the directory entry
// has a table, then the table memory; both reads are registered. A release reads and checks
// each directory entry of the process in turn and walks each table that it finds, streaming
// the table memory one entry a cycle. After reset a clearing pass over max(NUM_PROCESSES,
// NUM_FRAMES) * 1024 entries (32768 by default) runs with s_ready low. Results sit in an
// output register, so the next item is taken while a result waits.
module two_level_page_table_allocator #(
    parameter int NUM_PROCESSES = tlpa_pkg::DEF_NUM_PROCESSES,
    parameter int NUM_FRAMES    = tlpa_pkg::DEF_NUM_FRAMES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpa_pkg::tlpa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpa_pkg::tlpa_out_t m_data
);

    import tlpa_pkg::*;

    logic      res_valid, res_ready;
    tlpa_out_t res_data;

    logic      m_valid_reg, m_valid_next;
    tlpa_out_t m_data_reg, m_data_next;

    tlpa_ctrl #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_FRAMES    (NUM_FRAMES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .s_ready   (s_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Take a new result when the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) m_data_next = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/tlpa_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
module tlpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tlpa_ctrl.sv @@
// Table sequencer: directory, second-level pool and free-frame ring memories.
module tlpa_ctrl #(
    parameter int NUM_PROCESSES = tlpa_pkg::DEF_NUM_PROCESSES,
    parameter int NUM_FRAMES    = tlpa_pkg::DEF_NUM_FRAMES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  tlpa_pkg::tlpa_in_t s_data,
    output logic               s_ready,
    output logic               res_valid,
    input  logic               res_ready,
    output tlpa_pkg::tlpa_out_t res_data
);

    import tlpa_pkg::*;

    localparam int PROC_W      = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int COUNT_W     = $clog2(NUM_FRAMES + 1);
    localparam int DIR_DEPTH   = NUM_PROCESSES * DIR_ENTRIES;
    localparam int PAGE_DEPTH  = NUM_FRAMES * PAGE_ENTRIES;
    localparam int DIR_AW      = $clog2(DIR_DEPTH);
    localparam int PAGE_AW     = FRAME_W + PAGE_IDX_W;
    localparam int DIR_W       = FRAME_W + 2;
    localparam int PAGE_W      = FRAME_W + 1;
    localparam int SWEEP_DEPTH = (DIR_DEPTH > PAGE_DEPTH) ? DIR_DEPTH : PAGE_DEPTH;
    localparam int SWEEP_W     = $clog2(SWEEP_DEPTH);
    localparam int PCNT_W      = PAGE_IDX_W + 1;

    localparam logic [SWEEP_W-1:0] SWEEP_LAST     = SWEEP_W'(SWEEP_DEPTH - 1);
    localparam logic [SWEEP_W:0]   DIR_DEPTH_C    = (SWEEP_W + 1)'(DIR_DEPTH);
    localparam logic [SWEEP_W:0]   PAGE_DEPTH_C   = (SWEEP_W + 1)'(PAGE_DEPTH);
    localparam logic [SWEEP_W:0]   RING_DEPTH_C   = (SWEEP_W + 1)'(NUM_FRAMES);
    localparam logic [FRAME_W-1:0] RING_LAST      = FRAME_W'(NUM_FRAMES - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL     = COUNT_W'(NUM_FRAMES);
    localparam logic [PCNT_W-1:0]  PAGE_CNT_END   = PCNT_W'(PAGE_ENTRIES);
    localparam logic [DIR_IDX_W-1:0] DIR_IDX_LAST = DIR_IDX_W'(DIR_ENTRIES - 1);

    tlpa_state_t state_reg, state_next;

    logic [SWEEP_W-1:0]    sweep_reg, sweep_next;
    logic [FRAME_W-1:0]    head_reg, head_next;
    logic [FRAME_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [PROC_W-1:0]     proc_reg, proc_next;
    logic [DIR_IDX_W-1:0]  dir_idx_reg, dir_idx_next;
    logic [PAGE_IDX_W-1:0] page_idx_reg, page_idx_next;
    logic [OFFSET_W-1:0]   off_reg, off_next;
    logic [FRAME_W-1:0]    slot_reg, slot_next;
    logic [PCNT_W-1:0]     p_rd_reg, p_rd_next;
    logic [COUNT_W-1:0]    returned_reg, returned_next;

    // Process index reduced modulo the process count
    logic [PROC_W-1:0] proc_tab [2**PROC_ID_W];
    logic [PROC_W-1:0] proc_in;

    for (genvar i = 0; i < 2**PROC_ID_W; i++) begin : g_proc_tab
        assign proc_tab[i] = PROC_W'(i % NUM_PROCESSES);
    end

    assign proc_in = proc_tab[s_data.process_id];

    logic [PROC_W+DIR_IDX_W-1:0] dir_cat_in, dir_cat_reg;
    logic [DIR_AW-1:0]           dir_addr_in, dir_addr_reg;

    assign dir_cat_in   = {proc_in, s_data.virtual_address[DIR_SHIFT +: DIR_IDX_W]};
    assign dir_cat_reg  = {proc_reg, dir_idx_reg};
    assign dir_addr_in  = dir_cat_in[DIR_AW-1:0];
    assign dir_addr_reg = dir_cat_reg[DIR_AW-1:0];

    // Memory ports
    logic               dir_we;
    logic [DIR_AW-1:0]  dir_waddr, dir_raddr;
    logic [DIR_W-1:0]   dir_wdata, dir_rdata;
    logic               page_we;
    logic [PAGE_AW-1:0] page_waddr, page_raddr;
    logic [PAGE_W-1:0]  page_wdata, page_rdata;
    logic               ring_we;
    logic [FRAME_W-1:0] ring_waddr;
    logic [FRAME_W-1:0] ring_wdata, ring_rdata;

    tlpa_ram #(.WIDTH(DIR_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlpa_ram #(.WIDTH(PAGE_W), .DEPTH(PAGE_DEPTH)) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    tlpa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // Directory entry: valid, table present, table slot
    logic               dir_v, dir_hs;
    logic [FRAME_W-1:0] dir_slot;
    logic               pg_v;
    logic [FRAME_W-1:0] pg_f;
    logic               have_frame, ring_full, dir_last, p_rd_done;
    logic [FRAME_W-1:0] head_inc, tail_inc;
    logic [PCNT_W-1:0]  p_wr_cnt;
    logic [SWEEP_W:0]   sweep_ext;

    assign dir_v      = dir_rdata[DIR_W-1];
    assign dir_hs     = dir_rdata[DIR_W-2];
    assign dir_slot   = dir_rdata[FRAME_W-1:0];
    assign pg_v       = page_rdata[FRAME_W];
    assign pg_f       = page_rdata[FRAME_W-1:0];
    assign have_frame = (count_reg != '0);
    assign ring_full  = (count_reg == COUNT_FULL);
    assign dir_last   = (dir_idx_reg == DIR_IDX_LAST);
    assign p_rd_done  = (p_rd_reg == PAGE_CNT_END);
    assign head_inc   = (head_reg == RING_LAST) ? '0 : head_reg + FRAME_W'(1);
    assign tail_inc   = (tail_reg == RING_LAST) ? '0 : tail_reg + FRAME_W'(1);
    assign p_wr_cnt   = p_rd_reg - PCNT_W'(1);
    assign sweep_ext  = {1'b0, sweep_reg};

    logic pop, push;

    logic                res_mapped;
    logic [STATUS_W-1:0] res_status;
    logic                res_dfault, res_pfault;
    logic [FRAME_W-1:0]  res_frame;
    logic [31:0]         res_frame_wide, returned_wide;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_reg == SWEEP_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.action == ACTION_RELEASE) ? ST_REL_DIR_RD : ST_TR_DIR;
                end
            end
            ST_TR_DIR: begin
                if (dir_v && dir_hs) state_next = ST_TR_PAGE;
                else if (res_ready) state_next = ST_IDLE;
            end
            ST_TR_PAGE: begin
                if (res_ready) state_next = ST_IDLE;
            end
            ST_REL_DIR_RD: state_next = ST_REL_DIR_CHK;
            ST_REL_DIR_CHK: begin
                if (dir_v && dir_hs) state_next = ST_REL_PAGE;
                else if (dir_last) state_next = ST_REL_DONE;
                else state_next = ST_REL_DIR_RD;
            end
            ST_REL_PAGE: begin
                if (p_rd_done) state_next = dir_last ? ST_REL_DONE : ST_REL_DIR_RD;
            end
            ST_REL_DONE: begin
                if (res_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Memory controls and result
    always_comb begin
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        res_mapped = 1'b0;
        res_status = STATUS_MAPPED;
        res_dfault = 1'b0;
        res_pfault = 1'b0;
        res_frame  = '0;
        dir_raddr  = dir_addr_reg;
        dir_we     = 1'b0;
        dir_waddr  = dir_addr_reg;
        dir_wdata  = '0;
        page_raddr = {slot_reg, page_idx_reg};
        page_we    = 1'b0;
        page_waddr = {slot_reg, page_idx_reg};
        page_wdata = '0;
        ring_we    = 1'b0;
        ring_waddr = tail_reg;
        ring_wdata = '0;
        pop        = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ST_INIT: begin
                // clear tables, load ring with frames in order
                dir_we     = (sweep_ext < DIR_DEPTH_C);
                dir_waddr  = sweep_reg[DIR_AW-1:0];
                page_we    = (sweep_ext < PAGE_DEPTH_C);
                page_waddr = sweep_reg[PAGE_AW-1:0];
                ring_we    = (sweep_ext < RING_DEPTH_C);
                ring_waddr = sweep_reg[FRAME_W-1:0];
                ring_wdata = sweep_reg[FRAME_W-1:0];
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                dir_raddr = dir_addr_in;
            end
            ST_TR_DIR: begin
                page_raddr = {dir_slot, page_idx_reg};
                if (!(dir_v && dir_hs)) begin
                    // no table yet: the page is unmapped; a frame handed out for it becomes the slot
                    res_valid  = 1'b1;
                    res_dfault = !dir_v;
                    res_pfault = 1'b1;
                    if (have_frame) begin
                        res_mapped = 1'b1;
                        res_frame  = ring_rdata;
                        page_we    = res_ready;
                        page_waddr = {ring_rdata, page_idx_reg};
                        page_wdata = {1'b1, ring_rdata};
                        dir_we     = res_ready;
                        dir_wdata  = {1'b1, 1'b1, ring_rdata};
                        pop        = res_ready;
                    end else begin
                        res_status = STATUS_OUT_OF_FRAMES;
                        dir_we     = res_ready && !dir_v;
                        dir_wdata  = {1'b1, 1'b0, {FRAME_W{1'b0}}};
                    end
                end
            end
            ST_TR_PAGE: begin
                res_valid = 1'b1;
                if (pg_v) begin
                    res_mapped = 1'b1;
                    res_frame  = pg_f;
                end else begin
                    res_pfault = 1'b1;
                    if (have_frame) begin
                        res_mapped = 1'b1;
                        res_frame  = ring_rdata;
                        page_we    = res_ready;
                        page_wdata = {1'b1, ring_rdata};
                        pop        = res_ready;
                    end else begin
                        res_status = STATUS_OUT_OF_FRAMES;
                    end
                end
            end
            ST_REL_DIR_CHK: begin
                dir_we = dir_v;
            end
            ST_REL_PAGE: begin
                page_raddr = {slot_reg, p_rd_reg[PAGE_IDX_W-1:0]};
                page_waddr = {slot_reg, p_wr_cnt[PAGE_IDX_W-1:0]};
                if (p_rd_reg != '0 && pg_v) begin
                    page_we    = 1'b1;
                    ring_wdata = pg_f;
                    ring_we    = !ring_full;
                    push       = !ring_full;
                end
            end
            ST_REL_DONE: begin
                res_valid  = 1'b1;
                res_status = STATUS_RELEASE_DONE;
            end
            default: ;
        endcase
    end

    assign res_frame_wide = 32'(res_frame);
    assign returned_wide  = (state_reg == ST_REL_DONE) ? 32'(returned_reg) : 32'd0;

    always_comb begin
        res_data                  = '0;
        res_data.status           = res_status;
        res_data.dir_fault        = res_dfault;
        res_data.page_fault       = res_pfault;
        res_data.frames_returned  = returned_wide[RETURNED_W-1:0];
        if (res_mapped) begin
            res_data.frame            = res_frame_wide[FRAME_OUT_W-1:0];
            res_data.physical_address = {res_frame_wide[FRAME_OUT_W-1:0], off_reg};
        end
    end

    // Register next values
    always_comb begin
        sweep_next    = sweep_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        proc_next     = proc_reg;
        dir_idx_next  = dir_idx_reg;
        page_idx_next = page_idx_reg;
        off_next      = off_reg;
        slot_next     = slot_reg;
        p_rd_next     = p_rd_reg;
        returned_next = returned_reg;
        case (state_reg)
            ST_INIT: sweep_next = sweep_reg + SWEEP_W'(1);
            ST_IDLE: begin
                if (s_valid) begin
                    proc_next     = proc_in;
                    dir_idx_next  = (s_data.action == ACTION_RELEASE) ? '0
                                  : s_data.virtual_address[DIR_SHIFT +: DIR_IDX_W];
                    page_idx_next = s_data.virtual_address[PAGE_SHIFT +: PAGE_IDX_W];
                    off_next      = s_data.virtual_address[OFFSET_W-1:0];
                    returned_next = '0;
                end
            end
            ST_TR_DIR: slot_next = dir_slot;
            ST_REL_DIR_CHK: begin
                slot_next = dir_slot;
                p_rd_next = '0;
                if (!(dir_v && dir_hs) && !dir_last) dir_idx_next = dir_idx_reg + DIR_IDX_W'(1);
            end
            ST_REL_PAGE: begin
                if (!p_rd_done) p_rd_next = p_rd_reg + PCNT_W'(1);
                else if (!dir_last) dir_idx_next = dir_idx_reg + DIR_IDX_W'(1);
            end
            default: ;
        endcase
        if (pop) begin
            head_next  = head_inc;
            count_next = count_reg - COUNT_W'(1);
        end
        if (push) begin
            tail_next     = tail_inc;
            count_next    = count_reg + COUNT_W'(1);
            returned_next = returned_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= COUNT_FULL;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        proc_reg     <= proc_next;
        dir_idx_reg  <= dir_idx_next;
        page_idx_reg <= page_idx_next;
        off_reg      <= off_next;
        slot_reg     <= slot_next;
        p_rd_reg     <= p_rd_next;
        returned_reg <= returned_next;
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the two-level page table allocator.
`timescale 1ns / 1ps

module testbench;
    import tlpa_pkg::*;

    localparam int NPROC        = DEF_NUM_PROCESSES;
    localparam int NFRAMES      = DEF_NUM_FRAMES;
    localparam int RANDOM_ITEMS = 1810;
    // Covers the clearing pass after reset and a release walking every table.
    localparam int IDLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_AT  = 400;
    localparam int HOLD_OFF_LEN = 3000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tlpa_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tlpa_out_t m_data;

    two_level_page_table_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror of the translation tables and the free-frame ring
    bit                     dir_present [NPROC*DIR_ENTRIES];
    logic [FRAME_OUT_W-1:0] page_frame_of [int unsigned];
    logic [FRAME_OUT_W-1:0] free_ring [NFRAMES];
    int unsigned            ring_head  = 0;
    int unsigned            ring_tail  = 0;
    int unsigned            ring_count = NFRAMES;

    tlpa_in_t  pending_requests [$];
    tlpa_out_t expected_results [$];

    int mismatches      = 0;
    int translations    = 0;
    int releases        = 0;
    int dir_faults      = 0;
    int page_faults     = 0;
    int starved         = 0;
    int frames_back     = 0;
    int results_checked = 0;
    int idle_cycles     = 0;

    function automatic tlpa_out_t map_request(tlpa_in_t req);
        tlpa_out_t   res;
        int unsigned pid;
        int unsigned dir_slot;
        int unsigned page_slot;
        int unsigned k;
        int unsigned owned [$];
        int          returned;
        res      = '0;
        returned = 0;
        pid      = req.process_id % NPROC;
        if (req.action == ACTION_RELEASE) begin
            releases++;
            for (int d = 0; d < DIR_ENTRIES; d++) begin
                dir_present[pid*DIR_ENTRIES + d] = 1'b0;
            end
            // Keys sort by directory then page, which is the return order.
            if (page_frame_of.first(k)) begin
                do begin
                    if (k / (DIR_ENTRIES*PAGE_ENTRIES) == pid) owned.push_back(k);
                end while (page_frame_of.next(k));
            end
            foreach (owned[i]) begin
                if (ring_count < NFRAMES) begin
                    free_ring[ring_tail] = page_frame_of[owned[i]];
                    ring_tail = (ring_tail + 1) % NFRAMES;
                    ring_count++;
                    returned++;
                end
                page_frame_of.delete(owned[i]);
            end
            frames_back += returned;
            res.status          = STATUS_RELEASE_DONE;
            res.frames_returned = returned[RETURNED_W-1:0];
        end else begin
            translations++;
            dir_slot  = pid*DIR_ENTRIES + (req.virtual_address >> DIR_SHIFT);
            page_slot = dir_slot*PAGE_ENTRIES
                      + ((req.virtual_address >> PAGE_SHIFT) % PAGE_ENTRIES);
            res.status = STATUS_MAPPED;
            if (!dir_present[dir_slot]) begin
                dir_present[dir_slot] = 1'b1;
                res.dir_fault = 1'b1;
                dir_faults++;
            end
            if (!page_frame_of.exists(page_slot)) begin
                res.page_fault = 1'b1;
                page_faults++;
                if (ring_count > 0) begin
                    page_frame_of[page_slot] = free_ring[ring_head];
                    ring_head = (ring_head + 1) % NFRAMES;
                    ring_count--;
                end else begin
                    res.status = STATUS_OUT_OF_FRAMES;
                    starved++;
                end
            end
            if (res.status == STATUS_MAPPED) begin
                res.frame            = page_frame_of[page_slot];
                res.physical_address = {res.frame, req.virtual_address[OFFSET_W-1:0]};
            end
        end
        return res;
    endfunction

    function automatic void queue_request(logic action, logic [PROC_ID_W-1:0] pid,
                                          logic [VADDR_W-1:0] va);
        tlpa_in_t r;
        r.action          = action;
        r.process_id      = pid;
        r.virtual_address = va;
        pending_requests.push_back(r);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Request side: bursts of random length separated by random gaps
    int  burst_left = 1;
    int  gap_left   = 0;
    bit  offer_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            // Ring starts with every frame in order
            for (int f = 0; f < NFRAMES; f++) free_ring[f] = FRAME_OUT_W'(f);
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(map_request(s_data));
                offer_next = 1'b0;
            end else begin
                offer_next = s_valid;
            end
            if (!offer_next && pending_requests.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    s_data <= pending_requests.pop_front();
                    offer_next = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_valid <= offer_next;
        end
    end

    // Result side: check each transfer and stall on a pattern of its own
    tlpa_out_t   want;
    int          ready_mode      = 0;
    int          mode_left       = 1;
    logic [15:0] stall_bits      = '1;
    int          hold_off_left   = 0;
    bit          hold_off_done   = 1'b0;
    bit          ready_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer, status %0d", m_data.status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, m_data.status);
                    compare_field("dir_fault", want.dir_fault, m_data.dir_fault);
                    compare_field("page_fault", want.page_fault, m_data.page_fault);
                    compare_field("frame", want.frame, m_data.frame);
                    compare_field("physical_address", want.physical_address,
                                  m_data.physical_address);
                    compare_field("frames_returned", want.frames_returned,
                                  m_data.frames_returned);
                end
                results_checked++;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                ready_next = 1'b0;
            end else if (!hold_off_done && results_checked >= HOLD_OFF_AT) begin
                // Back-pressure long enough for the block to stall its input.
                hold_off_done = 1'b1;
                hold_off_left = HOLD_OFF_LEN;
                ready_next    = 1'b0;
            end else begin
                mode_left--;
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(2);
                    mode_left  = $urandom_range(50, 300);
                    stall_bits = 16'($urandom);
                end
                case (ready_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = stall_bits[0];
                    default: ready_next = ($urandom_range(3) != 0);
                endcase
                stall_bits = {stall_bits[0], stall_bits[15:1]};
            end
            m_ready <= ready_next;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    localparam logic [DIR_IDX_W-1:0] HOT_DIRS [4] = '{10'd0, 10'd1023, 10'h155, 10'h2AA};
    localparam logic [PAGE_IDX_W-1:0] HOT_PAGES [4] = '{10'd0, 10'd1023, 10'd1, 10'd512};

    initial begin
        int unsigned             roll;
        logic [DIR_IDX_W-1:0]    dir_idx;
        logic [PAGE_IDX_W-1:0]   page_idx;
        logic [PROC_ID_W-1:0]    pid;

        // Fresh map, hit with offset extremes, top directory and page
        queue_request(ACTION_TRANSLATE, 3'd0, 32'h0000_0000);
        queue_request(ACTION_TRANSLATE, 3'd0, 32'h0000_0FFF);
        queue_request(ACTION_TRANSLATE, 3'd7, 32'hFFFF_FFFF);
        queue_request(ACTION_TRANSLATE, 3'd7, 32'hFFC0_0ABC);
        queue_request(ACTION_TRANSLATE, 3'd4, 32'h1234_5678);
        // Drain the ring through one table of one process
        for (int n = 0; n < NFRAMES - 4; n++) begin
            queue_request(ACTION_TRANSLATE, 3'd2, {10'd1, 10'(n), 12'(n * 149)});
        end
        // Empty ring: existing and fresh directory, then a hit still works
        queue_request(ACTION_TRANSLATE, 3'd2, {10'd1, 10'd28, 12'hA5A});
        queue_request(ACTION_TRANSLATE, 3'd6, 32'h8000_0123);
        queue_request(ACTION_TRANSLATE, 3'd2, {10'd1, 10'd5, 12'h5A5});
        // Release with no pages, a full table, then nothing left
        queue_request(ACTION_RELEASE, 3'd6, 32'hFFFF_FFFF);
        queue_request(ACTION_RELEASE, 3'd2, 32'h0000_0000);
        queue_request(ACTION_RELEASE, 3'd2, 32'h5555_5555);
        queue_request(ACTION_TRANSLATE, 3'd0, 32'h0040_0000);
        queue_request(ACTION_TRANSLATE, 3'd2, {10'd1, 10'd0, 12'hFFF});
        queue_request(ACTION_RELEASE, 3'd7, 32'hAAAA_AAAA);

        // Mostly translations that revisit a few hot directories and pages
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            pid  = PROC_ID_W'($urandom_range(NPROC - 1));
            if (roll < 4) begin
                queue_request(ACTION_RELEASE, pid, $urandom);
            end else begin
                dir_idx  = ($urandom_range(99) < 60) ? HOT_DIRS[$urandom_range(3)]
                                                     : 10'($urandom);
                page_idx = ($urandom_range(99) < 65) ? HOT_PAGES[$urandom_range(3)]
                                                     : 10'($urandom);
                queue_request(ACTION_TRANSLATE, pid, {dir_idx, page_idx, 12'($urandom)});
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d translations: %0d directory faults, %0d page faults, %0d starved",
                 translations, dir_faults, page_faults, starved);
        $display("%0d releases gave back %0d frames; %0d results checked",
                 releases, frames_back, results_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tlpa_pkg.sv
sv/tlpa_ram.sv
sv/tlpa_ctrl.sv
sv/two_level_page_table_allocator.sv
tb/testbench.sv
